// File: design/triangle_from_three_lines_macros.svh
// Assertion macros shared by the checker of triangle_from_three_lines.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TRIANGLE_FROM_THREE_LINES_MACROS_SVH
`define TRIANGLE_FROM_THREE_LINES_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tfl_pkg.sv
// Package for triangle_from_three_lines: widths, pipeline stage types and
// the magnitude helper. No dependencies.
`timescale 1ns / 1ps
package tfl_pkg;

  localparam int unsigned CoefW     = 16;
  localparam int unsigned FracW     = 16;
  localparam int unsigned DenW      = 32;
  localparam int unsigned AccW      = 48;
  localparam int unsigned QW        = 32;
  localparam int unsigned SqW       = 64;
  localparam int unsigned DivSteps  = 48;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned AreaShift = 17;
  localparam int unsigned NumLanes  = 6;

  // One division in flight: partial remainder, dividend/quotient shifter,
  // divisor magnitude and result sign.
  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [AccW-1:0] acc;
    logic [DenW-1:0] den;
    logic            neg;
  } div_lane_t;

  typedef struct packed {
    logic                          valid;
    logic                          par;
    div_lane_t [NumLanes-1:0]      lane;
  } div_stage_t;

  // One square root in flight: remaining value, partial root, overflow.
  typedef struct packed {
    logic [SqW-1:0] v;
    logic [SqW-1:0] res;
    logic           ovf;
  } sqrt_lane_t;

  typedef struct packed {
    logic                 valid;
    logic                 par;
    logic [2:0][QW-1:0]   px;
    logic [2:0][QW-1:0]   py;
    logic [QW-1:0]        area;
    logic [SqW-1:0]       bitm;
    sqrt_lane_t [2:0]     lane;
  } sqrt_stage_t;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

endpackage

// File: design/tfl_if.sv
// Channel interfaces for triangle_from_three_lines: three lines in, one
// triangle out. Depends on tfl_pkg.
`timescale 1ns / 1ps
interface tfl_in_if import tfl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CoefW-1:0] line1_a;
  logic signed [CoefW-1:0] line1_b;
  logic signed [CoefW-1:0] line1_c;
  logic signed [CoefW-1:0] line2_a;
  logic signed [CoefW-1:0] line2_b;
  logic signed [CoefW-1:0] line2_c;
  logic signed [CoefW-1:0] line3_a;
  logic signed [CoefW-1:0] line3_b;
  logic signed [CoefW-1:0] line3_c;

  modport source (output valid, line1_a, line1_b, line1_c, line2_a, line2_b, line2_c,
                  line3_a, line3_b, line3_c, input ready);
  modport sink   (input valid, line1_a, line1_b, line1_c, line2_a, line2_b, line2_c,
                  line3_a, line3_b, line3_c, output ready);
endinterface

interface tfl_out_if import tfl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] p12_x;
  logic signed [QW-1:0] p12_y;
  logic signed [QW-1:0] p23_x;
  logic signed [QW-1:0] p23_y;
  logic signed [QW-1:0] p31_x;
  logic signed [QW-1:0] p31_y;
  logic [QW-1:0]        side_12_23;
  logic [QW-1:0]        side_23_31;
  logic [QW-1:0]        side_31_12;
  logic [QW-1:0]        tri_area;
  logic                 parallel_found;

  modport source (output valid, p12_x, p12_y, p23_x, p23_y, p31_x, p31_y, side_12_23,
                  side_23_31, side_31_12, tri_area, parallel_found, input ready);
  modport sink   (input valid, p12_x, p12_y, p23_x, p23_y, p31_x, p31_y, side_12_23,
                  side_23_31, side_31_12, tri_area, parallel_found, output ready);
endinterface

// File: design/tfl_det.sv
// Front stage: Cramer determinants for the three line pairs, loaded into
// the divider lanes. Depends on tfl_pkg.
`timescale 1ns / 1ps
module tfl_det import tfl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2:0][CoefW-1:0] a_i,
  input  logic [2:0][CoefW-1:0] b_i,
  input  logic [2:0][CoefW-1:0] c_i,
  output div_stage_t            s_o
);

  div_stage_t pay_d, pay_q;
  logic       valid_q;

  always_comb begin
    logic signed [2*CoefW-1:0] p_ab, p_ba, p_bc, p_cb, p_ac, p_ca;
    logic signed [2*CoefW:0]   d, nx, ny;
    int unsigned               j;
    pay_d       = pay_q;
    pay_d.valid = valid_i;
    pay_d.par   = 1'b0;
    for (int unsigned i = 0; i < 3; i++) begin
      j    = (i == 2) ? 0 : i + 1;
      p_ab = $signed(a_i[i]) * $signed(b_i[j]);
      p_ba = $signed(a_i[j]) * $signed(b_i[i]);
      p_bc = $signed(b_i[j]) * $signed(c_i[i]);
      p_cb = $signed(b_i[i]) * $signed(c_i[j]);
      p_ac = $signed(a_i[i]) * $signed(c_i[j]);
      p_ca = $signed(a_i[j]) * $signed(c_i[i]);
      d    = 33'(p_ab) - 33'(p_ba);
      nx   = 33'(p_bc) - 33'(p_cb);
      ny   = 33'(p_ac) - 33'(p_ca);
      if (d == '0) begin
        pay_d.par = 1'b1;
      end
      pay_d.lane[2*i].rem   = '0;
      pay_d.lane[2*i].acc   = {mag33(nx), FracW'(0)};
      pay_d.lane[2*i].den   = mag33(d);
      pay_d.lane[2*i].neg   = nx[2*CoefW] ^ d[2*CoefW];
      pay_d.lane[2*i+1].rem = '0;
      pay_d.lane[2*i+1].acc = {mag33(ny), FracW'(0)};
      pay_d.lane[2*i+1].den = mag33(d);
      pay_d.lane[2*i+1].neg = ny[2*CoefW] ^ d[2*CoefW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    s_o       = pay_q;
    s_o.valid = valid_q;
  end

endmodule

// File: design/tfl_div_cell.sv
// One restoring-division cell: produces one quotient bit for each of the
// six coordinate lanes and hands the lanes on. Depends on tfl_pkg.
`timescale 1ns / 1ps
module tfl_div_cell import tfl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  div_stage_t s_i,
  output div_stage_t s_o
);

  div_stage_t pay_d, pay_q;
  logic       valid_q;

  always_comb begin
    logic [DenW:0] trial, diff;
    logic          ge;
    pay_d = s_i;
    for (int unsigned l = 0; l < NumLanes; l++) begin
      trial = {s_i.lane[l].rem, s_i.lane[l].acc[AccW-1]};
      diff  = trial - {1'b0, s_i.lane[l].den};
      ge    = !diff[DenW];
      pay_d.lane[l].rem = ge ? diff[DenW-1:0] : trial[DenW-1:0];
      pay_d.lane[l].acc = {s_i.lane[l].acc[AccW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= s_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    s_o       = pay_q;
    s_o.valid = valid_q;
  end

endmodule

// File: design/tfl_geo.sv
// Geometry stages: saturate the quotients to vertices, take differences,
// square and multiply, then form the squared sides and the area.
// Four register stages. Depends on tfl_pkg.
`timescale 1ns / 1ps
module tfl_geo import tfl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  div_stage_t  s_i,
  output sqrt_stage_t s_o
);

  // Stage 1: vertices.
  logic               v1_q, par1_q;
  logic [2:0][QW-1:0] px1_q, py1_q;
  logic [NumLanes-1:0][QW-1:0] q_sat;

  // Stage 2: difference magnitudes and signs.
  logic               v2_q, par2_q;
  logic [2:0][QW-1:0] px2_q, py2_q;
  logic [2:0][QW-1:0] dxm_q, dym_q;
  logic [3:0][QW-1:0] um_q;
  logic [3:0]         us_q;
  logic [2:0][QW-1:0] dxm_d, dym_d;
  logic [3:0][QW-1:0] um_d;
  logic [3:0]         us_d;

  // Stage 3: products.
  logic                v3_q, par3_q;
  logic [2:0][QW-1:0]  px3_q, py3_q;
  logic [2:0][SqW-1:0] sx_q, sy_q;
  logic [SqW-1:0]      pm_q, qm_q;
  logic                pneg_q, qneg_q;

  // Stage 4: sums.
  sqrt_stage_t pay_d, pay_q;
  logic        v4_q;

  always_comb begin
    logic [AccW-1:0] q;
    logic            big;
    for (int unsigned l = 0; l < NumLanes; l++) begin
      q = s_i.lane[l].acc;
      if (s_i.lane[l].neg) begin
        big      = (|q[AccW-1:QW]) || (q[QW-1] && (|q[QW-2:0]));
        q_sat[l] = big ? {1'b1, {(QW-1){1'b0}}} : QW'(0) - q[QW-1:0];
      end else begin
        big      = |q[AccW-1:QW-1];
        q_sat[l] = big ? {1'b0, {(QW-1){1'b1}}} : q[QW-1:0];
      end
    end
  end

  always_comb begin
    logic signed [QW:0] dx, dy;
    logic signed [QW:0] u [4];
    int unsigned        k1;
    for (int unsigned k = 0; k < 3; k++) begin
      k1 = (k == 2) ? 0 : k + 1;
      dx = $signed({px1_q[k][QW-1], px1_q[k]}) - $signed({px1_q[k1][QW-1], px1_q[k1]});
      dy = $signed({py1_q[k][QW-1], py1_q[k]}) - $signed({py1_q[k1][QW-1], py1_q[k1]});
      dxm_d[k] = mag33(dx);
      dym_d[k] = mag33(dy);
    end
    u[0] = $signed({px1_q[1][QW-1], px1_q[1]}) - $signed({px1_q[0][QW-1], px1_q[0]});
    u[1] = $signed({py1_q[2][QW-1], py1_q[2]}) - $signed({py1_q[0][QW-1], py1_q[0]});
    u[2] = $signed({px1_q[2][QW-1], px1_q[2]}) - $signed({px1_q[0][QW-1], px1_q[0]});
    u[3] = $signed({py1_q[1][QW-1], py1_q[1]}) - $signed({py1_q[0][QW-1], py1_q[0]});
    for (int unsigned n = 0; n < 4; n++) begin
      um_d[n] = mag33(u[n]);
      us_d[n] = u[n][QW];
    end
  end

  always_comb begin
    logic [SqW:0] sum, m;
    logic         pn, qn, sat;
    pay_d       = pay_q;
    pay_d.valid = v3_q;
    pay_d.par   = par3_q;
    pay_d.px    = px3_q;
    pay_d.py    = py3_q;
    pay_d.bitm  = SqW'(1) << (SqW - 2);
    for (int unsigned k = 0; k < 3; k++) begin
      sum = {1'b0, sx_q[k]} + {1'b0, sy_q[k]};
      pay_d.lane[k].v   = sum[SqW-1:0];
      pay_d.lane[k].res = '0;
      pay_d.lane[k].ovf = sum[SqW];
    end
    // A zero product carries no sign.
    pn = pneg_q && (pm_q != '0);
    qn = qneg_q && (qm_q != '0);
    if (pn != qn) begin
      m = {1'b0, pm_q} + {1'b0, qm_q};
    end else if (pm_q >= qm_q) begin
      m = {1'b0, pm_q - qm_q};
    end else begin
      m = {1'b0, qm_q - pm_q};
    end
    sat        = |m[SqW:AreaShift+QW];
    pay_d.area = sat ? '1 : m[AreaShift+QW-1:AreaShift];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= s_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      par1_q <= s_i.par;
      for (int unsigned k = 0; k < 3; k++) begin
        px1_q[k] <= q_sat[2*k];
        py1_q[k] <= q_sat[2*k+1];
      end
      par2_q <= par1_q;
      px2_q  <= px1_q;
      py2_q  <= py1_q;
      dxm_q  <= dxm_d;
      dym_q  <= dym_d;
      um_q   <= um_d;
      us_q   <= us_d;
      par3_q <= par2_q;
      px3_q  <= px2_q;
      py3_q  <= py2_q;
      for (int unsigned k = 0; k < 3; k++) begin
        sx_q[k] <= SqW'(dxm_q[k]) * SqW'(dxm_q[k]);
        sy_q[k] <= SqW'(dym_q[k]) * SqW'(dym_q[k]);
      end
      pm_q   <= SqW'(um_q[0]) * SqW'(um_q[1]);
      qm_q   <= SqW'(um_q[2]) * SqW'(um_q[3]);
      pneg_q <= us_q[0] ^ us_q[1];
      qneg_q <= us_q[2] ^ us_q[3];
      pay_q  <= pay_d;
    end
  end

  always_comb begin
    s_o       = pay_q;
    s_o.valid = v4_q;
  end

endmodule

// File: design/tfl_sqrt_cell.sv
// One integer square-root cell: a single digit-pair step for each of the
// three sides, with the trial bit carried along. Depends on tfl_pkg.
`timescale 1ns / 1ps
module tfl_sqrt_cell import tfl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  sqrt_stage_t s_i,
  output sqrt_stage_t s_o
);

  sqrt_stage_t pay_d, pay_q;
  logic        valid_q;

  always_comb begin
    logic [SqW-1:0] t;
    pay_d      = s_i;
    pay_d.bitm = s_i.bitm >> 2;
    for (int unsigned k = 0; k < 3; k++) begin
      t = s_i.lane[k].res + s_i.bitm;
      if (s_i.lane[k].v >= t) begin
        pay_d.lane[k].v   = s_i.lane[k].v - t;
        pay_d.lane[k].res = (s_i.lane[k].res >> 1) + s_i.bitm;
      end else begin
        pay_d.lane[k].res = s_i.lane[k].res >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= s_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    s_o       = pay_q;
    s_o.valid = valid_q;
  end

endmodule

// File: design/triangle_from_three_lines.sv
// Triangle from three lines: a pipeline of determinant, divider, geometry
// and square-root cells with an output register. Depends on tfl_pkg,
// tfl_if, tfl_det, tfl_div_cell, tfl_geo and tfl_sqrt_cell.
//
// Usage:
//   in_i takes one word per cycle while in_i.ready is high: three lines a*x+b*y=c, signed Q8.8.
//   out_o gives one word per input word: the three pairwise intersections,
//   the three side lengths and the area, all Q16.16 and saturated. If any
//   pair of lines is parallel, parallel_found is set and all else is zero.
//   From acceptance to out_o.valid a word passes through one determinant
//   stage, 48 divider cells (one quotient bit each), four geometry stages,
//   32 square-root cells (one root bit each) and the output register.
//   Throughput is one word per cycle while out_o is not stalled; every stage is a
//   register, so a new word enters each cycle while up to 86 words are in flight.
//   When out_o is stalled with a word held, the whole pipeline holds and
//   in_i.ready drops; in_i.ready is high whenever the output register is
//   empty or being read.
//   Reset clears all valid bits; the data registers are not reset.
`timescale 1ns / 1ps
module triangle_from_three_lines import tfl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfl_in_if.sink    in_i,
  tfl_out_if.source out_o
);

  logic                  adv;
  logic [2:0][CoefW-1:0] la, lb, lc;
  div_stage_t            div_s  [DivSteps+1];
  sqrt_stage_t           sqrt_s [SqrtSteps+1];
  sqrt_stage_t           last;
  logic                  out_valid_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  assign la = {in_i.line3_a, in_i.line2_a, in_i.line1_a};
  assign lb = {in_i.line3_b, in_i.line2_b, in_i.line1_b};
  assign lc = {in_i.line3_c, in_i.line2_c, in_i.line1_c};

  tfl_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_i.valid),
    .a_i     (la),
    .b_i     (lb),
    .c_i     (lc),
    .s_o     (div_s[0])
  );

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    tfl_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .s_i    (div_s[g]),
      .s_o    (div_s[g+1])
    );
  end

  tfl_geo u_geo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .s_i    (div_s[DivSteps]),
    .s_o    (sqrt_s[0])
  );

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    tfl_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .s_i    (sqrt_s[g]),
      .s_o    (sqrt_s[g+1])
    );
  end

  assign last = sqrt_s[SqrtSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_o.parallel_found <= last.par;
      if (last.par) begin
        out_o.p12_x      <= '0;
        out_o.p12_y      <= '0;
        out_o.p23_x      <= '0;
        out_o.p23_y      <= '0;
        out_o.p31_x      <= '0;
        out_o.p31_y      <= '0;
        out_o.side_12_23 <= '0;
        out_o.side_23_31 <= '0;
        out_o.side_31_12 <= '0;
        out_o.tri_area   <= '0;
      end else begin
        out_o.p12_x      <= last.px[0];
        out_o.p12_y      <= last.py[0];
        out_o.p23_x      <= last.px[1];
        out_o.p23_y      <= last.py[1];
        out_o.p31_x      <= last.px[2];
        out_o.p31_y      <= last.py[2];
        out_o.side_12_23 <= last.lane[0].ovf ? '1 : last.lane[0].res[QW-1:0];
        out_o.side_23_31 <= last.lane[1].ovf ? '1 : last.lane[1].res[QW-1:0];
        out_o.side_31_12 <= last.lane[2].ovf ? '1 : last.lane[2].res[QW-1:0];
        out_o.tri_area   <= last.area;
      end
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

// File: design/tfl_checker.sv
// Port-level checker for triangle_from_three_lines and its bind.
// Depends on tfl_pkg and triangle_from_three_lines_macros.svh.
`timescale 1ns / 1ps
`include "triangle_from_three_lines_macros.svh"
module tfl_checker import tfl_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [QW-1:0] p12_x_i,
  input logic [QW-1:0] p12_y_i,
  input logic [QW-1:0] p23_x_i,
  input logic [QW-1:0] p23_y_i,
  input logic [QW-1:0] p31_x_i,
  input logic [QW-1:0] p31_y_i,
  input logic [QW-1:0] side_12_23_i,
  input logic [QW-1:0] side_23_31_i,
  input logic [QW-1:0] side_31_12_i,
  input logic [QW-1:0] tri_area_i,
  input logic          parallel_found_i
);

  // A parallel pair leaves every numeric field of the word at zero.
  `TFL_ASSERT_NOW(a_par_zero, out_valid_i && parallel_found_i,
    p12_x_i == '0 && p12_y_i == '0 && p23_x_i == '0 && p23_y_i == '0 &&
    p31_x_i == '0 && p31_y_i == '0 && side_12_23_i == '0 && side_23_31_i == '0 &&
    side_31_12_i == '0 && tri_area_i == '0, "parallel word has nonzero fields")

  // An empty output register never back-pressures the input.
  `TFL_ASSERT_NOW(a_ready_empty, !out_valid_i, in_ready_i, "input stalled with output empty")

  // A held output word stalls the whole pipeline.
  `TFL_ASSERT_NOW(a_ready_stall, out_valid_i && !out_ready_i, !in_ready_i,
    "input taken while output stalled")

  // A stalled output word stays put.
  `TFL_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(p12_x_i) && $stable(p23_y_i) && $stable(side_31_12_i) &&
    $stable(tri_area_i) && $stable(parallel_found_i), "stalled output word changed")

endmodule

bind triangle_from_three_lines tfl_checker u_tfl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .p12_x_i          (out_o.p12_x),
  .p12_y_i          (out_o.p12_y),
  .p23_x_i          (out_o.p23_x),
  .p23_y_i          (out_o.p23_y),
  .p31_x_i          (out_o.p31_x),
  .p31_y_i          (out_o.p31_y),
  .side_12_23_i     (out_o.side_12_23),
  .side_23_31_i     (out_o.side_23_31),
  .side_31_12_i     (out_o.side_31_12),
  .tri_area_i       (out_o.tri_area),
  .parallel_found_i (out_o.parallel_found)
);

// File: sim/tb_triangle_from_three_lines.sv
// Testbench for triangle_from_three_lines: drives line triples, predicts the
// triangle words and compares them field by field. Depends on tfl_pkg, tfl_if, triangle_from_three_lines.
`timescale 1ns / 1ps
module tb_triangle_from_three_lines;
  import tfl_pkg::*;

  typedef struct packed {
    logic signed [15:0] l1a, l1b, l1c, l2a, l2b, l2c, l3a, l3b, l3c;
  } lines_t;

  typedef struct packed {
    logic [31:0] p12x, p12y, p23x, p23y, p31x, p31y;
    logic [31:0] s1, s2, s3, area;
    logic        par;
  } tri_t;

  typedef struct {
    lines_t ln;
    bit     known;
    tri_t   res;
  } row_t;

  localparam int NumRandom = 640;
  localparam int Latency   = 86;

  logic clk_i;
  logic rst_ni;
  tfl_in_if  in_ch();
  tfl_out_if out_ch();

  triangle_from_three_lines DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  tri_t   pending_tris[$];
  int     errors;
  bit     sending_done;
  row_t   rows[$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Quotient (num << 16) / den, truncated toward zero and saturated.
  function automatic logic signed [63:0] fix_div(input logic signed [63:0] num,
                                                 input logic signed [63:0] den);
    logic [63:0] q;
    bit          neg;
    neg = (num < 0) != (den < 0);
    q = (mag64(num) << 16) / mag64(den);
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -$signed(q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return $signed(q);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] distance(input logic signed [63:0] xa, ya, xb, yb);
    logic [63:0] dx, dy, sx, sy, sum;
    dx = mag64(xa - xb);
    dy = mag64(ya - yb);
    sx = dx * dx;
    sy = dy * dy;
    sum = sx + sy;
    if (sum < sx) return 32'hFFFF_FFFF;
    return 32'(int_sqrt(sum));
  endfunction

  function automatic tri_t predict_triangle(input lines_t ln);
    logic signed [63:0] a[3], b[3], c[3], px[3], py[3];
    logic signed [63:0] d, u1, v1, u2, v2;
    logic [63:0]        pm, qm, m, r;
    bit                 pneg, qneg, wrap;
    tri_t               t;
    int                 j;
    t = '0;
    a[0] = 64'(ln.l1a); b[0] = 64'(ln.l1b); c[0] = 64'(ln.l1c);
    a[1] = 64'(ln.l2a); b[1] = 64'(ln.l2b); c[1] = 64'(ln.l2c);
    a[2] = 64'(ln.l3a); b[2] = 64'(ln.l3b); c[2] = 64'(ln.l3c);
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      d = a[i] * b[j] - a[j] * b[i];
      if (d == 0) begin
        t.par = 1'b1;
        return t;
      end
      px[i] = fix_div(b[j] * c[i] - b[i] * c[j], d);
      py[i] = fix_div(a[i] * c[j] - a[j] * c[i], d);
    end
    t.p12x = px[0][31:0]; t.p12y = py[0][31:0];
    t.p23x = px[1][31:0]; t.p23y = py[1][31:0];
    t.p31x = px[2][31:0]; t.p31y = py[2][31:0];
    t.s1 = distance(px[0], py[0], px[1], py[1]);
    t.s2 = distance(px[1], py[1], px[2], py[2]);
    t.s3 = distance(px[2], py[2], px[0], py[0]);
    u1 = px[1] - px[0]; v1 = py[2] - py[0];
    u2 = px[2] - px[0]; v2 = py[1] - py[0];
    pm = mag64(u1) * mag64(v1);
    qm = mag64(u2) * mag64(v2);
    pneg = (pm != 0) && ((u1 < 0) != (v1 < 0));
    qneg = (qm != 0) && ((u2 < 0) != (v2 < 0));
    wrap = 1'b0;
    if (pneg != qneg) begin
      m = pm + qm;
      wrap = m < pm;
    end else begin
      m = pm >= qm ? pm - qm : qm - pm;
    end
    r = m >> AreaShift;
    t.area = (wrap || r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    return t;
  endfunction

  function automatic lines_t random_lines();
    lines_t ln;
    int     mode;
    ln = lines_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    mode = $urandom_range(0, 9);
    // Small coefficients keep vertices in range, so side and area math is deep.
    if (mode < 5) begin
      ln.l1a = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      ln.l1b = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      ln.l2a = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      ln.l2b = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      ln.l3a = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      ln.l3b = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
    end else if (mode == 5) begin
      // Line 3 parallel to line 1.
      ln.l3a = ln.l1a;
      ln.l3b = ln.l1b;
    end else if (mode == 6) begin
      ln.l1a = ln.l1a >>> 2;
      ln.l1b = ln.l1b >>> 2;
      ln.l2a = ln.l1a * 16'sd2;
      ln.l2b = ln.l1b * 16'sd2;
    end
    return ln;
  endfunction

  task automatic add_row(input lines_t ln, input bit known, input tri_t res);
    row_t r;
    r.ln = ln;
    r.known = known;
    r.res = res;
    rows.push_back(r);
  endtask

  task automatic check_word(input tri_t exp_t, input tri_t got);
    if (got.p12x != exp_t.p12x)
      $error("p12_x expected %h got %h", exp_t.p12x, got.p12x);
    if (got.p12y != exp_t.p12y)
      $error("p12_y expected %h got %h", exp_t.p12y, got.p12y);
    if (got.p23x != exp_t.p23x)
      $error("p23_x expected %h got %h", exp_t.p23x, got.p23x);
    if (got.p23y != exp_t.p23y)
      $error("p23_y expected %h got %h", exp_t.p23y, got.p23y);
    if (got.p31x != exp_t.p31x)
      $error("p31_x expected %h got %h", exp_t.p31x, got.p31x);
    if (got.p31y != exp_t.p31y)
      $error("p31_y expected %h got %h", exp_t.p31y, got.p31y);
    if (got.s1 != exp_t.s1)
      $error("side_12_23 expected %h got %h", exp_t.s1, got.s1);
    if (got.s2 != exp_t.s2)
      $error("side_23_31 expected %h got %h", exp_t.s2, got.s2);
    if (got.s3 != exp_t.s3)
      $error("side_31_12 expected %h got %h", exp_t.s3, got.s3);
    if (got.area != exp_t.area)
      $error("tri_area expected %h got %h", exp_t.area, got.area);
    if (got.par != exp_t.par)
      $error("parallel_found expected %b got %b", exp_t.par, got.par);
    if (got != exp_t) errors++;
  endtask

  // Stimulus: directed table first, then random triples.
  initial begin
    tri_t   par_word;
    tri_t   none;
    tri_t   unit_tri;
    tri_t   exp_t;
    lines_t ln;
    int     gap;
    par_word = '0;
    par_word.par = 1'b1;
    none = '0;
    // x=0, y=0, x+y=1 (Q8.8): vertices (0,0), (1,0), (0,1).
    unit_tri = '0;
    unit_tri.p23x = 32'h0001_0000;
    unit_tri.p31y = 32'h0001_0000;
    unit_tri.s1 = 32'h0001_0000;
    unit_tri.s2 = 32'h0001_6A09;
    unit_tri.s3 = 32'h0001_0000;
    unit_tri.area = 32'h0000_8000;
    errors = 0;
    sending_done = 1'b0;
    in_ch.valid <= 1'b0;
    {in_ch.line1_a, in_ch.line1_b, in_ch.line1_c, in_ch.line2_a, in_ch.line2_b,
     in_ch.line2_c, in_ch.line3_a, in_ch.line3_b, in_ch.line3_c} <= '0;
    add_row('0, 1'b1, par_word);
    add_row('{16'sh0100, 0, 0, 0, 16'sh0100, 0, 16'sh0100, 16'sh0100, 16'sh0100},
            1'b1, unit_tri);
    add_row('{16'sh0100, 0, 0, 16'sh0200, 0, 16'sh0100, 0, 16'sh0100, 0},
            1'b1, par_word);
    add_row('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b0, none);
    add_row('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
              16'sh8000, 16'sh8000, 16'sh7FFF}, 1'b0, none);
    add_row('{16'sh0001, 16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh0001, 16'sh8000,
              16'sh0001, 16'sh0001, 16'sh0000}, 1'b0, none);
    add_row('{16'sh0001, 16'sh0002, 16'sh7FFF, 16'sh0001, 16'sh0003, 16'sh8000,
              16'shFFFF, 16'sh0001, 16'sh7FFF}, 1'b0, none);
    add_row('{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'sh0000, 16'shFFFF,
              16'sh0000, 16'shFFFF, 16'shFFFF}, 1'b0, none);
    add_row('{16'sh0100, 16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh0100, 16'sh8000,
              16'sh0100, 16'sh0100, 16'sh8000}, 1'b0, none);
    add_row('{16'sh5555, 16'shAAAA, 16'sh1234, 16'shAAAA, 16'sh5556, 16'shEDCB,
              16'sh0F0F, 16'shF0F0, 16'sh7FFF}, 1'b0, none);
    add_row('{16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 16'sh0200,
              16'sh0000, 16'sh0100, 16'sh0000}, 1'b1, par_word);
    for (int i = 0; i < NumRandom; i++) add_row(random_lines(), 1'b0, none);

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (rows[i]) begin
      ln = rows[i].ln;
      exp_t = rows[i].known ? rows[i].res : predict_triangle(ln);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_ch.valid   <= 1'b1;
      in_ch.line1_a <= ln.l1a; in_ch.line1_b <= ln.l1b; in_ch.line1_c <= ln.l1c;
      in_ch.line2_a <= ln.l2a; in_ch.line2_b <= ln.l2b; in_ch.line2_c <= ln.l2c;
      in_ch.line3_a <= ln.l3a; in_ch.line3_b <= ln.l3b; in_ch.line3_c <= ln.l3c;
      @(posedge clk_i);
      while (in_ch.ready !== 1'b1) @(posedge clk_i);
      pending_tris.push_back(exp_t);
    end
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result side: random stalls and comparison against the oldest expectation.
  initial begin
    int   stall;
    tri_t got;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_ch.ready && out_ch.valid === 1'b1) begin
        got = {out_ch.p12_x, out_ch.p12_y, out_ch.p23_x, out_ch.p23_y, out_ch.p31_x,
               out_ch.p31_y, out_ch.side_12_23, out_ch.side_23_31, out_ch.side_31_12,
               out_ch.tri_area, out_ch.parallel_found};
        if (pending_tris.size() == 0) begin
          $error("triangle word with no expectation waiting");
          errors++;
        end else begin
          check_word(pending_tris.pop_front(), got);
        end
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (sending_done && pending_tris.size() == 0);
    repeat (Latency + 20) @(posedge clk_i);
    if (errors == 0 && pending_tris.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/tfl_pkg.sv
design/tfl_if.sv
design/tfl_det.sv
design/tfl_div_cell.sv
design/tfl_geo.sv
design/tfl_sqrt_cell.sv
design/triangle_from_three_lines.sv
design/tfl_checker.sv
sim/tb_triangle_from_three_lines.sv
